>>> rtl/sc2a_pkg.sv
// ============================================================================
// sc2a_pkg
// Shared types, scancode constants and Set 1 translation tables for the
// scancode-to-ASCII block.
// ============================================================================
package sc2a_pkg;

    // Set 1 codes of interest
    localparam logic [6:0] CODE_LSHIFT = 7'h2A;
    localparam logic [6:0] CODE_RSHIFT = 7'h36;
    localparam logic [6:0] CODE_CAPS   = 7'h3A;

    // Command queue between front and back
    localparam int CQ_DEPTH = 2;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    // One command for the back end: a pop request or a character to push
    typedef struct packed {
        logic       is_pop;
        logic [6:0] ch;
    } cmd_t;

    // Unshifted table, zero for unmapped codes
    function automatic logic [6:0] plain_map(input logic [6:0] code);
        logic [6:0] c;
        case (code)
            7'h02: c = 7'h31;  7'h03: c = 7'h32;  7'h04: c = 7'h33;  7'h05: c = 7'h34;
            7'h06: c = 7'h35;  7'h07: c = 7'h36;  7'h08: c = 7'h37;  7'h09: c = 7'h38;
            7'h0A: c = 7'h39;  7'h0B: c = 7'h30;  7'h0C: c = 7'h2D;  7'h0D: c = 7'h3D;
            7'h0E: c = 7'h08;  7'h0F: c = 7'h09;
            7'h10: c = 7'h71;  7'h11: c = 7'h77;  7'h12: c = 7'h65;  7'h13: c = 7'h72;
            7'h14: c = 7'h74;  7'h15: c = 7'h79;  7'h16: c = 7'h75;  7'h17: c = 7'h69;
            7'h18: c = 7'h6F;  7'h19: c = 7'h70;  7'h1A: c = 7'h5B;  7'h1B: c = 7'h5D;
            7'h1C: c = 7'h0A;  7'h1E: c = 7'h61;  7'h1F: c = 7'h73;
            7'h20: c = 7'h64;  7'h21: c = 7'h66;  7'h22: c = 7'h67;  7'h23: c = 7'h68;
            7'h24: c = 7'h6A;  7'h25: c = 7'h6B;  7'h26: c = 7'h6C;  7'h27: c = 7'h3B;
            7'h28: c = 7'h27;  7'h29: c = 7'h60;  7'h2B: c = 7'h5C;
            7'h2C: c = 7'h7A;  7'h2D: c = 7'h78;  7'h2E: c = 7'h63;  7'h2F: c = 7'h76;
            7'h30: c = 7'h62;  7'h31: c = 7'h6E;  7'h32: c = 7'h6D;  7'h33: c = 7'h2C;
            7'h34: c = 7'h2E;  7'h35: c = 7'h2F;  7'h37: c = 7'h2A;  7'h39: c = 7'h20;
            7'h47: c = 7'h37;  7'h48: c = 7'h38;  7'h49: c = 7'h39;  7'h4A: c = 7'h2D;
            7'h4B: c = 7'h34;  7'h4C: c = 7'h35;  7'h4D: c = 7'h36;  7'h4E: c = 7'h2B;
            7'h4F: c = 7'h31;  7'h50: c = 7'h32;  7'h51: c = 7'h33;  7'h52: c = 7'h30;
            7'h53: c = 7'h2E;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    // Shifted table, zero for unmapped codes
    function automatic logic [6:0] upper_map(input logic [6:0] code);
        logic [6:0] c;
        case (code)
            7'h02: c = 7'h21;  7'h03: c = 7'h40;  7'h04: c = 7'h23;  7'h05: c = 7'h24;
            7'h06: c = 7'h25;  7'h07: c = 7'h5E;  7'h08: c = 7'h26;  7'h09: c = 7'h2A;
            7'h0A: c = 7'h28;  7'h0B: c = 7'h29;  7'h0C: c = 7'h5F;  7'h0D: c = 7'h2B;
            7'h0E: c = 7'h08;  7'h0F: c = 7'h09;
            7'h10: c = 7'h51;  7'h11: c = 7'h57;  7'h12: c = 7'h45;  7'h13: c = 7'h52;
            7'h14: c = 7'h54;  7'h15: c = 7'h59;  7'h16: c = 7'h55;  7'h17: c = 7'h49;
            7'h18: c = 7'h4F;  7'h19: c = 7'h50;  7'h1A: c = 7'h7B;  7'h1B: c = 7'h7D;
            7'h1C: c = 7'h0A;  7'h1E: c = 7'h41;  7'h1F: c = 7'h53;
            7'h20: c = 7'h44;  7'h21: c = 7'h46;  7'h22: c = 7'h47;  7'h23: c = 7'h48;
            7'h24: c = 7'h4A;  7'h25: c = 7'h4B;  7'h26: c = 7'h4C;  7'h27: c = 7'h3A;
            7'h28: c = 7'h22;  7'h29: c = 7'h7E;  7'h2B: c = 7'h7C;
            7'h2C: c = 7'h5A;  7'h2D: c = 7'h58;  7'h2E: c = 7'h43;  7'h2F: c = 7'h56;
            7'h30: c = 7'h42;  7'h31: c = 7'h4E;  7'h32: c = 7'h4D;  7'h33: c = 7'h3C;
            7'h34: c = 7'h3E;  7'h35: c = 7'h3F;  7'h37: c = 7'h2A;  7'h39: c = 7'h20;
            7'h47: c = 7'h37;  7'h48: c = 7'h38;  7'h49: c = 7'h39;  7'h4A: c = 7'h2D;
            7'h4B: c = 7'h34;  7'h4C: c = 7'h35;  7'h4D: c = 7'h36;  7'h4E: c = 7'h2B;
            7'h4F: c = 7'h31;  7'h50: c = 7'h32;  7'h51: c = 7'h33;  7'h52: c = 7'h30;
            7'h53: c = 7'h2E;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/sc2a_ifs.sv
// ============================================================================
// sc2a_ifs
// Valid/ready channel interfaces: key requests in, character results out.
// ============================================================================
interface sc2a_key_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] scan_byte;

    modport source (output valid, action, scan_byte, input ready);
    modport sink   (input valid, action, scan_byte, output ready);
endinterface

interface sc2a_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] ascii_char;
    logic       char_valid;

    modport source (output valid, ascii_char, char_valid, input ready);
    modport sink   (input valid, ascii_char, char_valid, output ready);
endinterface

>>> rtl/sc2a_front.sv
// ============================================================================
// sc2a_front
// Accepts key requests, tracks shift and caps lock, translates make codes
// and issues push or pop commands to the command queue.
// ============================================================================
module sc2a_front (
    input  logic            clk,
    input  logic            rst_n,
    sc2a_key_if.sink        keys,
    output logic            cmd_valid,
    output sc2a_pkg::cmd_t  cmd,
    input  logic            cmd_ready
);
    import sc2a_pkg::*;

    logic       shift_reg, shift_next;
    logic       caps_reg, caps_next;
    logic       accept;
    logic       is_release;
    logic       is_shift_key;
    logic [6:0] key;
    logic [6:0] xlat;

    assign keys.ready   = cmd_ready;
    assign accept       = keys.valid && cmd_ready;
    assign is_release   = keys.scan_byte[7];
    assign key          = keys.scan_byte[6:0];
    assign is_shift_key = key inside {CODE_LSHIFT, CODE_RSHIFT};

    // table lookup on the current modifier state
    assign xlat = (shift_reg ^ caps_reg) ? upper_map(key) : plain_map(key);

    // modifier updates and command generation
    always_comb
    begin
        shift_next = shift_reg;
        caps_next  = caps_reg;
        cmd_valid  = 1'b0;
        cmd.is_pop = keys.action;
        cmd.ch     = xlat;
        if (accept)
        begin
            if (keys.action)
            begin
                cmd_valid = 1'b1;
            end
            else if (is_release)
            begin
                if (is_shift_key)
                    shift_next = 1'b0;
            end
            else if (is_shift_key)
            begin
                shift_next = 1'b1;
            end
            else if (key == CODE_CAPS)
            begin
                caps_next = ~caps_reg;
            end
            else
            begin
                cmd_valid = (xlat != 7'h00);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 1'b0;
            caps_reg  <= 1'b0;
        end
        else
        begin
            shift_reg <= shift_next;
            caps_reg  <= caps_next;
        end
    end

endmodule

>>> rtl/sc2a_cmdq.sv
// ============================================================================
// sc2a_cmdq
// Short command queue that decouples the front end from the back end.
// ============================================================================
module sc2a_cmdq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  sc2a_pkg::cmd_t  in_cmd,
    output logic            in_ready,
    output logic            out_valid,
    output sc2a_pkg::cmd_t  out_cmd,
    input  logic            out_ready
);
    import sc2a_pkg::*;

    cmd_t                entry_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                push, pop;

    assign in_ready  = (cnt_reg != CQ_CNT_W'(CQ_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= in_cmd;
    end

endmodule

>>> rtl/sc2a_back.sv
// ============================================================================
// sc2a_back
// Executes queued commands against the character ring buffer and holds the
// pop result in an output register.
// ============================================================================
module sc2a_back #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  sc2a_pkg::cmd_t  cmd,
    output logic            cmd_ready,
    sc2a_char_if.source     chars
);
    import sc2a_pkg::*;

    localparam int               IDX_W    = $clog2(BUFFER_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUFFER_DEPTH - 1);

    logic [6:0]       char_store_mem [BUFFER_DEPTH];
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             out_valid_reg, out_valid_next;
    logic             hit_reg, hit_next;
    logic [6:0]       rd_data_reg;
    logic [IDX_W-1:0] wr_idx_inc;
    logic [IDX_W-1:0] rd_idx_inc;
    logic             empty, full;
    logic             cmd_fire, push_fire, pop_fire;

    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    assign wr_idx_inc = advance(wr_idx_reg);
    assign rd_idx_inc = advance(rd_idx_reg);
    assign empty      = (wr_idx_reg == rd_idx_reg);
    assign full       = (wr_idx_inc == rd_idx_reg);

    // a pop waits only while the output register is held by the sink
    assign cmd_ready = !cmd.is_pop || !out_valid_reg || chars.ready;
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign push_fire = cmd_fire && !cmd.is_pop;
    assign pop_fire  = cmd_fire && cmd.is_pop;

    // index and output register control
    always_comb
    begin
        wr_idx_next    = wr_idx_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg;
        hit_next       = hit_reg;
        if (push_fire && !full)
            wr_idx_next = wr_idx_inc;
        if (pop_fire)
        begin
            out_valid_next = 1'b1;
            hit_next       = !empty;
            if (!empty)
                rd_idx_next = rd_idx_inc;
        end
        else if (chars.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
            hit_reg       <= hit_next;
        end
    end

    // ring buffer write port
    always_ff @(posedge clk)
    begin
        if (push_fire && !full)
            char_store_mem[wr_idx_reg] <= cmd.ch;
    end

    // ring buffer read port, registered
    always_ff @(posedge clk)
    begin
        if (pop_fire && !empty)
            rd_data_reg <= char_store_mem[rd_idx_reg];
    end

    assign chars.valid      = out_valid_reg;
    assign chars.char_valid = hit_reg;
    assign chars.ascii_char = hit_reg ? rd_data_reg : 7'h00;

    // pop on an empty buffer gives a miss result
    a_empty_miss: assert property (@(posedge clk) disable iff (!rst_n)
        pop_fire && empty |=> out_valid_reg && !hit_reg)
        else $error("empty pop did not return a miss");

    // pop on a filled buffer consumes exactly one entry
    a_pop_adv: assert property (@(posedge clk) disable iff (!rst_n)
        pop_fire && !empty |=> hit_reg && rd_idx_reg != $past(rd_idx_reg))
        else $error("read index did not advance on pop");

    // a character pushed into a full buffer is dropped
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        push_fire && full |=> $stable(wr_idx_reg))
        else $error("write index moved on full buffer");

    // indices stay within the buffer
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_idx_reg <= LAST_IDX && rd_idx_reg <= LAST_IDX)
        else $error("ring index out of range");

endmodule

>>> rtl/scancode_to_ascii_fifo.sv
// ============================================================================
// scancode_to_ascii_fifo
// Set 1 keyboard scancode translator with a character ring buffer.
// ============================================================================
// Usage:
//   keys  : request channel. action 0 delivers scan_byte (bit 7 = release),
//           action 1 pops one character. A scancode request gives no result.
//   chars : one result per pop request: ascii_char and char_valid, or
//           char_valid 0 and ascii_char 0 when the buffer is empty.
// Throughput: one request per cycle while keys.ready is high. The front end
//   classifies and translates a request in the cycle it is accepted; the back
//   end executes one command per cycle on the character store while no pop
//   waits on a held result. Pop path: a pop goes through the command queue;
//   the store read and the output register load happen at the same edge,
//   and chars.valid rises with that register.
// The buffer holds BUFFER_DEPTH-1 characters; a character arriving while it
//   is full is dropped.
// Reset: clears shift, caps lock, both ring indices, the command queue and
//   the output register. Store contents are not cleared; no clearing pass.
// Stalls: while chars.ready is low a finished result is held. Scancodes keep
//   flowing until the next pop reaches the back end; that pop waits, later
//   commands queue behind it, and keys.ready drops once both queue entries
//   are taken.
// ============================================================================
module scancode_to_ascii_fifo #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    sc2a_key_if.sink     keys,
    sc2a_char_if.source  chars
);
    import sc2a_pkg::*;

    logic fq_valid, fq_ready;
    cmd_t fq_cmd;
    logic qb_valid, qb_ready;
    cmd_t qb_cmd;

    sc2a_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .keys      (keys),
        .cmd_valid (fq_valid),
        .cmd       (fq_cmd),
        .cmd_ready (fq_ready)
    );

    sc2a_cmdq u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_cmd    (fq_cmd),
        .in_ready  (fq_ready),
        .out_valid (qb_valid),
        .out_cmd   (qb_cmd),
        .out_ready (qb_ready)
    );

    sc2a_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (qb_valid),
        .cmd       (qb_cmd),
        .cmd_ready (qb_ready),
        .chars     (chars)
    );

endmodule

>>> verif/scancode_to_ascii_fifo_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// scancode_to_ascii_fifo_tb
// Self-checking bench for the Set 1 scancode translator. Key requests are
// sent in bursts while the result side stalls on its own pattern. A
// tracker follows the shift and caps state and the character ring, and it
// checks every pop result in order. A fill phase drives the ring to full
// and then drains it past empty.
// ============================================================================
module scancode_to_ascii_fifo_tb;
    import sc2a_pkg::*;

    localparam int DEPTH = 256;

    // Request kinds and scancode bits
    localparam logic       ACT_SCAN = 1'b0;
    localparam logic       ACT_POP  = 1'b1;
    localparam logic [7:0] REL_BIT  = 8'h80;
    localparam int         LAST_KEY = 8'h57;
    localparam int         RAND_REQUESTS = 800;

    typedef struct packed {
        logic [6:0] ch;
        logic       ok;
    } char_result_t;

    // Tracks modifier state and the character ring, and holds the
    // pop results that are still due from the block.
    class char_tracker;
        bit           shift_on;
        bit           caps_on;
        int           cap;
        logic [6:0]   ring[$];
        char_result_t due_chars[$];
        int           errors;
        logic [6:0]   plain_tbl [88];
        logic [6:0]   shift_tbl [88];

        function new(int depth);
            cap      = depth - 1;
            shift_on = 1'b0;
            caps_on  = 1'b0;
            errors   = 0;
            plain_tbl = '{
                7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
                7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
                7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
                7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
                7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
                7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
                7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
                7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
                7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
                7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
                7'h32, 7'h33, 7'h30, 7'h2E, 7'h00, 7'h00, 7'h00, 7'h00
            };
            shift_tbl = '{
                7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
                7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
                7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
                7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
                7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
                7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
                7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
                7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
                7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
                7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
                7'h32, 7'h33, 7'h30, 7'h2E, 7'h00, 7'h00, 7'h00, 7'h00
            };
        endfunction

        function logic [6:0] translate(logic [6:0] key, bit upper);
            if (key > LAST_KEY)
                return 7'h00;
            return upper ? shift_tbl[key] : plain_tbl[key];
        endfunction

        // Random make code that yields a character in both tables
        function logic [7:0] random_key();
            logic [6:0] key;
            do
                key = 7'($urandom_range(0, LAST_KEY));
            while (plain_tbl[key] == 7'h00);
            return {1'b0, key};
        endfunction

        function int pending();
            return due_chars.size();
        endfunction

        // Apply one accepted request to the tracked state
        function void take_request(logic act, logic [7:0] code);
            char_result_t res;
            logic [6:0]   ch;
            if (act == ACT_POP) begin
                if (ring.size() == 0) begin
                    res = '{ch: 7'h00, ok: 1'b0};
                end
                else begin
                    res.ch = ring.pop_front();
                    res.ok = 1'b1;
                end
                due_chars.push_back(res);
            end
            else if (code[7]) begin
                // only shift releases matter; caps release is ignored
                if (code[6:0] == CODE_LSHIFT || code[6:0] == CODE_RSHIFT)
                    shift_on = 1'b0;
            end
            else if (code[6:0] == CODE_LSHIFT || code[6:0] == CODE_RSHIFT) begin
                shift_on = 1'b1;
            end
            else if (code[6:0] == CODE_CAPS) begin
                caps_on = ~caps_on;
            end
            else begin
                ch = translate(code[6:0], shift_on ^ caps_on);
                // full ring drops the character
                if (ch != 7'h00 && ring.size() < cap)
                    ring.push_back(ch);
            end
        endfunction

        task report(string what, logic [6:0] got, logic [6:0] want);
            errors++;
            $display("ERROR at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
        endtask

        task check_char(logic [6:0] ch, logic ok);
            char_result_t want;
            if (due_chars.size() == 0) begin
                report("unexpected result, ascii_char", ch, 7'h00);
            end
            else begin
                want = due_chars.pop_front();
                if (ok !== want.ok)
                    report("char_valid", {6'd0, ok}, {6'd0, want.ok});
                if (ch !== want.ch)
                    report("ascii_char", ch, want.ch);
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    sc2a_key_if  keys_if();
    sc2a_char_if chars_if();

    char_tracker tracker;
    int          burst_left;
    int          rand_count;

    scancode_to_ascii_fifo #(
        .BUFFER_DEPTH (DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .keys  (keys_if.sink),
        .chars (chars_if.source)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Drop valid and let cycles pass
    task pause(int cycles);
        keys_if.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Send one request, opening a new burst with a gap when due
    task send_request(logic act, logic [7:0] code);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
                pause(gap);
        end
        burst_left--;
        keys_if.valid     <= 1'b1;
        keys_if.action    <= act;
        keys_if.scan_byte <= code;
        do
            @(posedge clk);
        while (!keys_if.ready);
        tracker.take_request(act, code);
        // ignored releases do not count as traffic
        if (act == ACT_POP || !code[7] || code[6:0] == CODE_LSHIFT ||
            code[6:0] == CODE_RSHIFT)
            rand_count++;
    endtask

    // Hold off until every pop result has come back
    task drain();
        keys_if.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() > 0)
            @(posedge clk);
        burst_left = 0;
    endtask

    // Typing: keys with optional shift, caps toggles, then some pops
    task type_session();
        int         n;
        logic [7:0] key;
        logic [6:0] sh;
        bit         use_shift;
        n = $urandom_range(1, 12);
        repeat (n) begin
            key       = tracker.random_key();
            use_shift = ($urandom_range(0, 3) == 0);
            sh        = $urandom_range(0, 1) ? CODE_LSHIFT : CODE_RSHIFT;
            if ($urandom_range(0, 9) == 0)
                send_request(ACT_SCAN, {1'b0, CODE_CAPS});
            if (use_shift)
                send_request(ACT_SCAN, {1'b0, sh});
            send_request(ACT_SCAN, key);
            if ($urandom_range(0, 1))
                send_request(ACT_SCAN, key | REL_BIT);
            if (use_shift)
                send_request(ACT_SCAN, {1'b1, sh});
        end
        repeat ($urandom_range(n / 2, n + 3))
            send_request(ACT_POP, 8'($urandom_range(0, 255)));
    endtask

    // Reset, stimulus and final verdict
    initial
    begin
        int kind;
        tracker = new(DEPTH);
        burst_left = 0;
        rand_count = 0;
        rst_n             <= 1'b0;
        keys_if.valid     <= 1'b0;
        keys_if.action    <= ACT_SCAN;
        keys_if.scan_byte <= 8'h00;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty pop, unmapped codes, table ends, modifiers
        send_request(ACT_POP, 8'h00);
        send_request(ACT_SCAN, 8'h00);
        send_request(ACT_SCAN, 8'h7F);
        send_request(ACT_SCAN, 8'h02);
        send_request(ACT_SCAN, 8'h53);
        send_request(ACT_SCAN, {1'b0, CODE_LSHIFT});
        send_request(ACT_SCAN, 8'h1E);
        send_request(ACT_SCAN, {1'b1, CODE_LSHIFT});
        send_request(ACT_SCAN, {1'b0, CODE_RSHIFT});
        send_request(ACT_SCAN, 8'h02);
        send_request(ACT_SCAN, {1'b1, CODE_RSHIFT});
        send_request(ACT_SCAN, {1'b0, CODE_CAPS});
        send_request(ACT_SCAN, 8'h1E);
        send_request(ACT_SCAN, {1'b1, CODE_CAPS});
        send_request(ACT_SCAN, {1'b0, CODE_LSHIFT});
        send_request(ACT_SCAN, 8'h1E);
        send_request(ACT_SCAN, {1'b1, CODE_LSHIFT});
        send_request(ACT_SCAN, 8'hFF);
        send_request(ACT_SCAN, {1'b0, CODE_CAPS});
        repeat (6) send_request(ACT_POP, 8'hFF);
        drain();

        // Fill past capacity, then drain past empty
        rand_count = 0;
        repeat (DEPTH + 6) send_request(ACT_SCAN, tracker.random_key());
        repeat (DEPTH + 2) send_request(ACT_POP, 8'($urandom_range(0, 255)));

        // Mostly typing, with noise, stray modifiers and drains mixed in
        while (rand_count < RAND_REQUESTS) begin
            kind = $urandom_range(0, 11);
            if (kind <= 6) begin
                type_session();
            end
            else if (kind <= 8) begin
                repeat ($urandom_range(1, 8))
                    send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
            else if (kind <= 10) begin
                send_request(ACT_SCAN, {$urandom_range(0, 1) ? 1'b1 : 1'b0,
                                        $urandom_range(0, 1) ? CODE_LSHIFT : CODE_RSHIFT});
                send_request(ACT_SCAN, tracker.random_key());
                send_request(ACT_SCAN, {1'b1, CODE_CAPS});
                send_request(ACT_POP, 8'h00);
            end
            else begin
                drain();
            end
        end

        // Wait out outstanding results and the pipeline
        drain();
        repeat (8) @(posedge clk);
        if (tracker.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Result side: check accepted results, stall in changing patterns
    initial
    begin
        int  mode;
        int  mode_left;
        int  hold;
        int  cyc;
        bit  rdy;
        mode_left = 0;
        hold      = 0;
        cyc       = 0;
        mode      = 0;
        chars_if.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (chars_if.valid && chars_if.ready)
                tracker.check_char(chars_if.ascii_char, chars_if.char_valid);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            cyc++;
            case (mode)
                0: rdy = 1'b1;
                1: rdy = 1'($urandom_range(0, 1));
                2: rdy = (cyc % 4 == 0);
                default:
                begin
                    // long stalls that back pops up into the request side
                    if (hold > 0) begin
                        hold--;
                        rdy = 1'b0;
                    end
                    else begin
                        rdy = 1'b1;
                        if ($urandom_range(0, 7) == 0)
                            hold = $urandom_range(5, 20);
                    end
                end
            endcase
            chars_if.ready <= rdy;
        end
    end

    // Watchdog
    initial
    begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
